FILE: rtl/lrp_pkg.sv
// Shared types and codes for the LR parse engine.
// Used by lrp_front, lrp_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package lrp_pkg;

  localparam logic [2:0] OPC_LOAD_ACTION = 3'd0;
  localparam logic [2:0] OPC_LOAD_PROD   = 3'd1;
  localparam logic [2:0] OPC_LOAD_BODY   = 3'd2;
  localparam logic [2:0] OPC_START       = 3'd3;
  localparam logic [2:0] OPC_TOKEN       = 3'd4;

  localparam logic [2:0] KIND_EMPTY    = 3'd0;
  localparam logic [2:0] KIND_SHIFT    = 3'd1;
  localparam logic [2:0] KIND_GOTO     = 3'd2;
  localparam logic [2:0] KIND_REDUCE   = 3'd3;
  localparam logic [2:0] KIND_ACCEPT   = 3'd4;
  localparam logic [2:0] KIND_CONFLICT = 3'd5;

  localparam logic [3:0] OUT_REDUCED  = 4'd0;
  localparam logic [3:0] OUT_SHIFTED  = 4'd1;
  localparam logic [3:0] OUT_ACCEPTED = 4'd2;
  localparam logic [3:0] OUT_NOACTION = 4'd3;
  localparam logic [3:0] OUT_CONFLICT = 4'd4;
  localparam logic [3:0] OUT_MISMATCH = 4'd5;
  localparam logic [3:0] OUT_OVERFLOW = 4'd6;
  localparam logic [3:0] OUT_IDLE     = 4'd7;
  localparam logic [3:0] OUT_CHAIN    = 4'd8;

  localparam logic [1:0] REG_START_STATE = 2'd0;

  typedef enum logic [2:0] {
    CLS_LOAD_ACTION,
    CLS_LOAD_PROD,
    CLS_LOAD_BODY,
    CLS_START,
    CLS_TOKEN,
    CLS_NOP
  } item_cls_t;

  typedef struct packed {
    item_cls_t  cls;
    logic [7:0] entry_state;
    logic [5:0] entry_symbol;
    logic [2:0] entry_kind;
    logic [7:0] entry_target;
    logic [6:0] prod_index;
    logic [5:0] prod_head;
    logic [3:0] prod_length;
    logic [3:0] body_position;
    logic [5:0] body_symbol;
    logic [5:0] token;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ACT,
    ST_RED_LEN,
    ST_RED_RD,
    ST_RED_CMP,
    ST_RED_POP,
    ST_RED_TOP,
    ST_EMIT
  } eng_state_t;

endpackage

FILE: rtl/lr_shift_reduce_parse_engine.sv
// Top level of the LR parse engine: APB register, front queue and engine.
// Depends on lrp_pkg, lrp_front and lrp_back.
`timescale 1ns / 1ps

// Table-driven LR parse engine. Load items (opcodes 0..2) fill the action
// table and production store; a start item resets the stacks and pushes
// start_state. A token item runs the automaton and yields one result per
// reduce plus a final result flagged by last. Steps in the engine
// sequencer: an item leaves the queue in IDLE; each lookup then passes
// through LOOKUP and ACT, and each reduce through RED_LEN, a RED_RD and
// RED_CMP pair per body symbol (a stack read and a body read through
// registered memory ports), RED_POP and RED_TOP. Every emitted result passes
// EMIT, where it waits while the result register is held by the sink. A
// two-entry input queue and a result register decouple both sides. Table,
// production and stack contents are undefined until written.
module lr_shift_reduce_parse_engine #(
  parameter int NUM_STATES       = 256,
  parameter int NUM_SYMBOLS      = 64,
  parameter int NUM_PRODUCTIONS  = 128,
  parameter int MAX_BODY         = 15,
  parameter int STACK_DEPTH      = 256,
  parameter int MAX_REDUCE_CHAIN = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  entry_state,
  input  logic [5:0]  entry_symbol,
  input  logic [2:0]  entry_kind,
  input  logic [7:0]  entry_target,
  input  logic [6:0]  prod_index,
  input  logic [5:0]  prod_head,
  input  logic [3:0]  prod_length,
  input  logic [3:0]  body_position,
  input  logic [5:0]  body_symbol,
  input  logic [5:0]  token,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  outcome,
  output logic [6:0]  production,
  output logic [7:0]  top_state,
  output logic [8:0]  stack_depth,
  output logic        last
);

  logic [7:0]     start_state;
  logic           q_valid;
  logic           q_pop;
  lrp_pkg::item_t q_item;
  logic           reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = ({1'b0, paddr[2]} == lrp_pkg::REG_START_STATE);
  assign prdata  = reg_hit ? {24'd0, start_state} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= 8'd0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      start_state <= pwdata[7:0];
    end
  end

  lrp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .valid         (in_valid),
    .ready         (in_ready),
    .opcode        (opcode),
    .entry_state   (entry_state),
    .entry_symbol  (entry_symbol),
    .entry_kind    (entry_kind),
    .entry_target  (entry_target),
    .prod_index    (prod_index),
    .prod_head     (prod_head),
    .prod_length   (prod_length),
    .body_position (body_position),
    .body_symbol   (body_symbol),
    .token         (token),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  lrp_back #(
    .NUM_STATES       (NUM_STATES),
    .NUM_SYMBOLS      (NUM_SYMBOLS),
    .NUM_PRODUCTIONS  (NUM_PRODUCTIONS),
    .MAX_BODY         (MAX_BODY),
    .STACK_DEPTH      (STACK_DEPTH),
    .MAX_REDUCE_CHAIN (MAX_REDUCE_CHAIN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .start_state (start_state),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .outcome     (outcome),
    .production  (production),
    .top_state   (top_state),
    .stack_depth (stack_depth),
    .last        (last)
  );

endmodule

FILE: rtl/lrp_front.sv
// Front end: accepts input items, decodes the opcode into an item class and
// queues them for the engine in a two-entry queue. Depends on lrp_pkg.
`timescale 1ns / 1ps

module lrp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid,
  output logic           ready,
  input  logic [2:0]     opcode,
  input  logic [7:0]     entry_state,
  input  logic [5:0]     entry_symbol,
  input  logic [2:0]     entry_kind,
  input  logic [7:0]     entry_target,
  input  logic [6:0]     prod_index,
  input  logic [5:0]     prod_head,
  input  logic [3:0]     prod_length,
  input  logic [3:0]     body_position,
  input  logic [5:0]     body_symbol,
  input  logic [5:0]     token,
  output logic           q_valid,
  output lrp_pkg::item_t q_item,
  input  logic           q_pop
);

  lrp_pkg::item_t    entries [2];
  lrp_pkg::item_t    item_in;
  lrp_pkg::item_cls_t cls;
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;

  always_comb begin
    case (opcode)
      lrp_pkg::OPC_LOAD_ACTION: cls = lrp_pkg::CLS_LOAD_ACTION;
      lrp_pkg::OPC_LOAD_PROD:   cls = lrp_pkg::CLS_LOAD_PROD;
      lrp_pkg::OPC_LOAD_BODY:   cls = lrp_pkg::CLS_LOAD_BODY;
      lrp_pkg::OPC_START:       cls = lrp_pkg::CLS_START;
      lrp_pkg::OPC_TOKEN:       cls = lrp_pkg::CLS_TOKEN;
      default:                  cls = lrp_pkg::CLS_NOP;
    endcase
  end

  always_comb begin
    item_in.cls           = cls;
    item_in.entry_state   = entry_state;
    item_in.entry_symbol  = entry_symbol;
    item_in.entry_kind    = entry_kind;
    item_in.entry_target  = entry_target;
    item_in.prod_index    = prod_index;
    item_in.prod_head     = prod_head;
    item_in.prod_length   = prod_length;
    item_in.body_position = body_position;
    item_in.body_symbol   = body_symbol;
    item_in.token         = token;
  end

  assign ready   = (count != 2'd2);
  assign push    = valid && ready;
  assign q_valid = (count != 2'd0);
  assign q_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: rtl/lrp_back.sv
// Back end: sequencer that owns the tables and stacks, runs loads, starts
// and tokens, and drives the registered result channel. Depends on lrp_pkg.
`timescale 1ns / 1ps

module lrp_back #(
  parameter int NUM_STATES       = 256,
  parameter int NUM_SYMBOLS      = 64,
  parameter int NUM_PRODUCTIONS  = 128,
  parameter int MAX_BODY         = 15,
  parameter int STACK_DEPTH      = 256,
  parameter int MAX_REDUCE_CHAIN = 63
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     start_state,
  input  logic           q_valid,
  input  lrp_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [3:0]     outcome,
  output logic [6:0]     production,
  output logic [7:0]     top_state,
  output logic [8:0]     stack_depth,
  output logic           last
);

  localparam int ACT_DEPTH  = NUM_STATES * NUM_SYMBOLS;
  localparam int AW         = $clog2(ACT_DEPTH);
  localparam int PW         = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;
  localparam int BODY_DEPTH = NUM_PRODUCTIONS * MAX_BODY;
  localparam int BW         = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;
  localparam int SAW        = $clog2(STACK_DEPTH);
  localparam int SPW        = $clog2(STACK_DEPTH + 1);

  logic [10:0] act_mem  [ACT_DEPTH];
  logic [5:0]  head_mem [NUM_PRODUCTIONS];
  logic [3:0]  len_mem  [NUM_PRODUCTIONS];
  logic [5:0]  body_mem [BODY_DEPTH];
  logic [7:0]  sst_mem  [STACK_DEPTH];
  logic [5:0]  ssym_mem [STACK_DEPTH];

  logic [10:0] act_q;
  logic [5:0]  head_q;
  logic [3:0]  len_q;
  logic [5:0]  body_q;
  logic [7:0]  sst_q;
  logic [5:0]  ssym_q;

  lrp_pkg::eng_state_t state, state_next;
  lrp_pkg::item_t      item;
  logic [SPW-1:0]      sp;
  logic [SPW-1:0]      base;
  logic [7:0]          top;
  logic                pend_valid;
  logic [5:0]          pend_sym;
  logic                running;
  logic [5:0]          reduces;
  logic                lk_ok;
  logic [7:0]          tgt;
  logic [3:0]          len;
  logic [5:0]          head;
  logic [3:0]          k;
  logic [3:0]          hold_outcome;
  logic [7:0]          hold_prod;
  logic                hold_last;

  logic [5:0]    cur_sym;
  logic [2:0]    kind;
  logic          is_push;
  logic          full;
  logic          chain_hit;
  logic          red_bad;
  logic          len_bad;
  logic          cmp_bad;
  logic          cmp_end;
  logic          out_free;
  logic          lookup_ok;

  logic          act_we;
  logic [AW-1:0] act_waddr;
  logic [AW-1:0] act_raddr;
  logic          prod_we;
  logic [PW-1:0] prod_waddr;
  logic [PW-1:0] prod_raddr;
  logic          body_we;
  logic [BW-1:0] body_waddr;
  logic [BW-1:0] body_raddr;
  logic           stk_we;
  logic [SAW-1:0] stk_waddr;
  logic [7:0]     stk_wstate;
  logic [5:0]     stk_wsym;
  logic [SAW-1:0] ssym_raddr;
  logic [SAW-1:0] sst_raddr;

  assign cur_sym   = pend_valid ? pend_sym : item.token;
  assign kind      = lk_ok ? act_q[10:8] : lrp_pkg::KIND_EMPTY;
  assign is_push   = (kind == lrp_pkg::KIND_SHIFT) || (kind == lrp_pkg::KIND_GOTO);
  assign full      = (int'(sp) >= STACK_DEPTH);
  assign chain_hit = (int'(reduces) >= MAX_REDUCE_CHAIN);
  assign red_bad   = pend_valid || (int'(act_q[7:0]) >= NUM_PRODUCTIONS);
  assign len_bad   = (int'(len_q) > MAX_BODY) || (sp == '0)
                     || ((sp - SPW'(1)) < SPW'(len_q));
  assign cmp_bad   = (ssym_q != body_q);
  assign cmp_end   = ((k + 4'd1) == len);
  assign out_free  = !out_valid || out_ready;
  assign lookup_ok = (sp != '0) && (int'(top) < NUM_STATES)
                     && (int'(cur_sym) < NUM_SYMBOLS);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lrp_pkg::ST_IDLE: begin
        if (q_valid && (q_item.cls == lrp_pkg::CLS_TOKEN)) begin
          state_next = running ? lrp_pkg::ST_LOOKUP : lrp_pkg::ST_EMIT;
        end
      end
      lrp_pkg::ST_LOOKUP: state_next = lrp_pkg::ST_ACT;
      lrp_pkg::ST_ACT: begin
        if (is_push) begin
          state_next = (!full && pend_valid) ? lrp_pkg::ST_LOOKUP : lrp_pkg::ST_EMIT;
        end else if (kind == lrp_pkg::KIND_REDUCE) begin
          state_next = (chain_hit || red_bad) ? lrp_pkg::ST_EMIT : lrp_pkg::ST_RED_LEN;
        end else begin
          state_next = lrp_pkg::ST_EMIT;
        end
      end
      lrp_pkg::ST_RED_LEN: begin
        if (len_bad) begin
          state_next = lrp_pkg::ST_EMIT;
        end else if (len_q == 4'd0) begin
          state_next = lrp_pkg::ST_RED_POP;
        end else begin
          state_next = lrp_pkg::ST_RED_RD;
        end
      end
      lrp_pkg::ST_RED_RD: state_next = lrp_pkg::ST_RED_CMP;
      lrp_pkg::ST_RED_CMP: begin
        if (cmp_bad) begin
          state_next = lrp_pkg::ST_EMIT;
        end else if (cmp_end) begin
          state_next = lrp_pkg::ST_RED_POP;
        end else begin
          state_next = lrp_pkg::ST_RED_RD;
        end
      end
      lrp_pkg::ST_RED_POP: state_next = lrp_pkg::ST_RED_TOP;
      lrp_pkg::ST_RED_TOP: state_next = lrp_pkg::ST_EMIT;
      lrp_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = hold_last ? lrp_pkg::ST_IDLE : lrp_pkg::ST_LOOKUP;
        end
      end
      default: state_next = lrp_pkg::ST_IDLE;
    endcase
  end

  // Memory ports and queue pop
  always_comb begin
    q_pop      = (state == lrp_pkg::ST_IDLE) && q_valid;
    act_we     = q_pop && (q_item.cls == lrp_pkg::CLS_LOAD_ACTION)
                 && (int'(q_item.entry_state) < NUM_STATES)
                 && (int'(q_item.entry_symbol) < NUM_SYMBOLS);
    act_waddr  = AW'(int'(q_item.entry_state) * NUM_SYMBOLS + int'(q_item.entry_symbol));
    act_raddr  = AW'(int'(top) * NUM_SYMBOLS + int'(cur_sym));
    prod_we    = q_pop && (q_item.cls == lrp_pkg::CLS_LOAD_PROD)
                 && (int'(q_item.prod_index) < NUM_PRODUCTIONS);
    prod_waddr = PW'(q_item.prod_index);
    prod_raddr = PW'(act_q[7:0]);
    body_we    = q_pop && (q_item.cls == lrp_pkg::CLS_LOAD_BODY)
                 && (int'(q_item.prod_index) < NUM_PRODUCTIONS)
                 && (int'(q_item.body_position) < MAX_BODY);
    body_waddr = BW'(int'(q_item.prod_index) * MAX_BODY + int'(q_item.body_position));
    body_raddr = BW'(int'(tgt) * MAX_BODY + int'(k));
    ssym_raddr = SAW'(base + SPW'(k));
    sst_raddr  = SAW'(base - SPW'(1));
    stk_we     = 1'b0;
    stk_waddr  = SAW'(sp);
    stk_wstate = act_q[7:0];
    stk_wsym   = cur_sym;
    if (q_pop && (q_item.cls == lrp_pkg::CLS_START)) begin
      stk_we     = 1'b1;
      stk_waddr  = '0;
      stk_wstate = start_state;
      stk_wsym   = 6'd0;
    end else if ((state == lrp_pkg::ST_ACT) && is_push && !full) begin
      stk_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_waddr] <= {q_item.entry_kind, q_item.entry_target};
    end
    act_q <= act_mem[act_raddr];
  end

  always_ff @(posedge clk) begin
    if (prod_we) begin
      head_mem[prod_waddr] <= q_item.prod_head;
      len_mem[prod_waddr]  <= q_item.prod_length;
    end
    head_q <= head_mem[prod_raddr];
    len_q  <= len_mem[prod_raddr];
  end

  always_ff @(posedge clk) begin
    if (body_we) begin
      body_mem[body_waddr] <= q_item.body_symbol;
    end
    body_q <= body_mem[body_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      sst_mem[stk_waddr]  <= stk_wstate;
      ssym_mem[stk_waddr] <= stk_wsym;
    end
    sst_q  <= sst_mem[sst_raddr];
    ssym_q <= ssym_mem[ssym_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lrp_pkg::ST_IDLE;
      sp         <= '0;
      top        <= 8'd0;
      pend_valid <= 1'b0;
      pend_sym   <= 6'd0;
      running    <= 1'b0;
      reduces    <= 6'd0;
    end else begin
      state <= state_next;
      case (state)
        lrp_pkg::ST_IDLE: begin
          if (q_pop && (q_item.cls == lrp_pkg::CLS_START)) begin
            sp         <= SPW'(1);
            top        <= start_state;
            pend_valid <= 1'b0;
            pend_sym   <= 6'd0;
            running    <= 1'b1;
          end
          if (q_pop && (q_item.cls == lrp_pkg::CLS_TOKEN)) begin
            reduces <= 6'd0;
          end
        end
        lrp_pkg::ST_ACT: begin
          if (is_push) begin
            if (full) begin
              running <= 1'b0;
            end else begin
              sp  <= sp + SPW'(1);
              top <= act_q[7:0];
              if (pend_valid) begin
                pend_valid <= 1'b0;
                pend_sym   <= 6'd0;
              end
            end
          end else if (kind == lrp_pkg::KIND_REDUCE) begin
            if (chain_hit || red_bad) begin
              running <= 1'b0;
            end
          end else begin
            running <= 1'b0;
          end
        end
        lrp_pkg::ST_RED_LEN: begin
          if (len_bad) begin
            running <= 1'b0;
          end
        end
        lrp_pkg::ST_RED_CMP: begin
          if (cmp_bad) begin
            running <= 1'b0;
          end
        end
        lrp_pkg::ST_RED_POP: begin
          sp         <= base;
          pend_valid <= 1'b1;
          pend_sym   <= head;
          reduces    <= reduces + 6'd1;
        end
        lrp_pkg::ST_RED_TOP: top <= sst_q;
        default: ;
      endcase
    end
  end

  // Datapath registers and pending result
  always_ff @(posedge clk) begin
    case (state)
      lrp_pkg::ST_IDLE: begin
        if (q_pop) begin
          item         <= q_item;
          hold_outcome <= lrp_pkg::OUT_IDLE;
          hold_prod    <= 8'd0;
          hold_last    <= 1'b1;
        end
      end
      lrp_pkg::ST_LOOKUP: lk_ok <= lookup_ok;
      lrp_pkg::ST_ACT: begin
        tgt       <= act_q[7:0];
        hold_prod <= 8'd0;
        hold_last <= 1'b1;
        if (is_push) begin
          hold_outcome <= full ? lrp_pkg::OUT_OVERFLOW : lrp_pkg::OUT_SHIFTED;
        end else if (kind == lrp_pkg::KIND_REDUCE) begin
          hold_outcome <= chain_hit ? lrp_pkg::OUT_CHAIN : lrp_pkg::OUT_MISMATCH;
        end else if (kind == lrp_pkg::KIND_ACCEPT) begin
          hold_outcome <= lrp_pkg::OUT_ACCEPTED;
        end else if (kind == lrp_pkg::KIND_CONFLICT) begin
          hold_outcome <= lrp_pkg::OUT_CONFLICT;
        end else begin
          hold_outcome <= lrp_pkg::OUT_NOACTION;
        end
      end
      lrp_pkg::ST_RED_LEN: begin
        len  <= len_q;
        head <= head_q;
        base <= sp - SPW'(len_q);
        k    <= 4'd0;
      end
      lrp_pkg::ST_RED_CMP: k <= k + 4'd1;
      lrp_pkg::ST_RED_TOP: begin
        hold_outcome <= lrp_pkg::OUT_REDUCED;
        hold_prod    <= tgt;
        hold_last    <= 1'b0;
      end
      default: ;
    endcase
  end

  // Result register: take the next result while the last one drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == lrp_pkg::ST_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == lrp_pkg::ST_EMIT) && out_free) begin
      outcome     <= hold_outcome;
      production  <= 7'(hold_prod);
      top_state   <= top;
      stack_depth <= 9'(sp);
      last        <= hold_last;
    end
  end

endmodule
